FILE: sv/lvd_pkg.sv
// ----------------------------------------------------------------------------
// lvd_pkg
// Shared widths, register indexes and fault codes of the local volatility
// pipeline.
// ----------------------------------------------------------------------------
package lvd_pkg;

	localparam int DW = 32;                    // field width
	localparam int FB = 16;                    // fraction bits
	localparam int NUM_W = 3 * DW + 4;         // signed numerator, scaled by 2^(3*FB)
	localparam int DEN_W = 3 * DW;             // unsigned K^2 * Ckk
	localparam int DIVW = 5 * DW + 1;          // dividend / remainder width
	localparam int QW = 2 * DW;                // quotient width before saturation
	localparam int SQW = 2 * DW + 1;           // root remainder width
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RATE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_YIELD = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		FLT_OK  = 2'd0,
		FLT_ARG = 2'd1,
		FLT_DEN = 2'd2,
		FLT_NUM = 2'd3
	} fault_t;

	typedef struct packed {
		fault_t fault;
		logic   sat;
	} meta_t;

endpackage

FILE: sv/lvd_front.sv
// ----------------------------------------------------------------------------
// lvd_front
// Three stages of split multiplies and sums forming the exact numerator and
// denominator, plus the argument checks.
// ----------------------------------------------------------------------------
module lvd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic signed [lvd_pkg::DW-1:0]     rate,
	input  logic signed [lvd_pkg::DW-1:0]     yield,
	input  logic signed [lvd_pkg::DW-1:0]     k,
	input  logic signed [lvd_pkg::DW-1:0]     t,
	input  logic signed [lvd_pkg::DW-1:0]     c,
	input  logic signed [lvd_pkg::DW-1:0]     ct,
	input  logic signed [lvd_pkg::DW-1:0]     ck,
	input  logic signed [lvd_pkg::DW-1:0]     ckk,
	output logic                              vld_s3,
	output lvd_pkg::fault_t                   fault_s3,
	output logic signed [lvd_pkg::NUM_W-1:0]  num_s3,
	output logic        [lvd_pkg::DEN_W-1:0]  den_s3
);

	localparam int DW = lvd_pkg::DW;
	localparam int FB = lvd_pkg::FB;
	localparam int NUM_W = lvd_pkg::NUM_W;
	localparam int DEN_W = lvd_pkg::DEN_W;

	// stage 1
	logic                   vld_s1;
	lvd_pkg::fault_t        fault_s1;
	logic signed [2*DW:0]   p1_s1;
	logic signed [2*DW-1:0] qc_s1;
	logic        [2*DW-1:0] kk_s1;
	logic signed [DW-1:0]   ct_s1;
	logic signed [DW-1:0]   ck_s1;
	logic        [DW-2:0]   ckk_s1;
	// stage 2
	logic                   vld_s2;
	lvd_pkg::fault_t        fault_s2;
	logic signed [2*DW:0]   pl_s2;
	logic signed [2*DW:0]   ph_s2;
	logic        [2*DW-1:0] dl_s2;
	logic        [2*DW-1:0] dh_s2;
	logic signed [2*DW-1:0] qc_s2;
	logic signed [DW-1:0]   ct_s2;

	logic signed [DW:0]     rq;
	lvd_pkg::fault_t        fault_in;
	logic signed [NUM_W-1:0] t_ct, t_ph, t_pl, t_qc, num_c;
	logic        [DEN_W-1:0] den_c;

	always_comb begin
		rq = $signed({rate[DW-1], rate}) - $signed({yield[DW-1], yield});
		if (k <= 0 || t <= 0) begin
			fault_in = lvd_pkg::FLT_ARG;
		end else if (ckk <= 0) begin
			fault_in = lvd_pkg::FLT_DEN;
		end else begin
			fault_in = lvd_pkg::FLT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fault_s1 <= fault_in;
			p1_s1    <= (2*DW+1)'(rq) * (2*DW+1)'(k);
			qc_s1    <= (2*DW)'(yield) * (2*DW)'(c);
			kk_s1    <= (2*DW)'(k[DW-2:0]) * (2*DW)'(k[DW-2:0]);
			ct_s1    <= ct;
			ck_s1    <= ck;
			ckk_s1   <= ckk[DW-2:0];
		end
	end

	// split the 65-bit rate product and K^2 into halves for the second multiply
	always_ff @(posedge clk) begin
		if (en) begin
			fault_s2 <= fault_s1;
			pl_s2    <= (2*DW+1)'($signed({1'b0, p1_s1[DW-1:0]})) * (2*DW+1)'(ck_s1);
			ph_s2    <= (2*DW+1)'($signed(p1_s1[2*DW:DW])) * (2*DW+1)'(ck_s1);
			dl_s2    <= (2*DW)'(kk_s1[DW-1:0]) * (2*DW)'(ckk_s1);
			dh_s2    <= (2*DW)'(kk_s1[2*DW-1:DW]) * (2*DW)'(ckk_s1);
			qc_s2    <= qc_s1;
			ct_s2    <= ct_s1;
		end
	end

	always_comb begin
		t_ct  = NUM_W'(ct_s2);
		t_ph  = NUM_W'(ph_s2);
		t_pl  = NUM_W'(pl_s2);
		t_qc  = NUM_W'(qc_s2);
		num_c = (t_ct <<< (2 * FB)) + (t_ph <<< DW) + t_pl + (t_qc <<< FB);
		den_c = (DEN_W'(dh_s2) << DW) + DEN_W'(dl_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= num_c;
			den_s3 <= den_c;
			if (fault_s2 == lvd_pkg::FLT_OK && num_c < 0) begin
				fault_s3 <= lvd_pkg::FLT_NUM;
			end else begin
				fault_s3 <= fault_s2;
			end
		end
	end

endmodule

FILE: sv/lvd_div.sv
// ----------------------------------------------------------------------------
// lvd_div
// Restoring divider, one quotient bit per stage, with an up-front overflow
// check that saturates quotients of 2^(2*DW) or more.
// ----------------------------------------------------------------------------
module lvd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_in,
	input  lvd_pkg::fault_t                   fault_in,
	input  logic signed [lvd_pkg::NUM_W-1:0]  num,
	input  logic        [lvd_pkg::DEN_W-1:0]  den,
	output logic                              vld_out,
	output lvd_pkg::meta_t                    meta_out,
	output logic        [lvd_pkg::QW-1:0]     quo_out
);

	localparam int FB = lvd_pkg::FB;
	localparam int NUM_W = lvd_pkg::NUM_W;
	localparam int DEN_W = lvd_pkg::DEN_W;
	localparam int DIVW = lvd_pkg::DIVW;
	localparam int QW = lvd_pkg::QW;

	logic                 vld_s  [0:QW];
	lvd_pkg::meta_t       meta_s [0:QW];
	logic [DIVW-1:0]      rem_s  [0:QW];
	logic [DEN_W-1:0]     den_s  [0:QW];
	logic [QW-1:0]        quo_s  [0:QW];

	logic [DIVW-1:0] dvd;

	assign dvd = DIVW'(num[NUM_W-2:0]) << (2 * FB + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0].fault <= fault_in;
			meta_s[0].sat   <= (dvd >= (DIVW'(den) << QW));
			rem_s[0]        <= dvd;
			den_s[0]        <= den;
			quo_s[0]        <= '0;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [DIVW:0] diff;

		assign diff = {1'b0, rem_s[j-1]} - ({1'b0, DIVW'(den_s[j-1])} << (QW - j));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		// keep the difference only when it did not borrow
		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[j] <= meta_s[j-1];
				den_s[j]  <= den_s[j-1];
				if (!diff[DIVW]) begin
					rem_s[j] <= diff[DIVW-1:0];
					quo_s[j] <= quo_s[j-1] | (QW'(1) << (QW - j));
				end else begin
					rem_s[j] <= rem_s[j-1];
					quo_s[j] <= quo_s[j-1];
				end
			end
		end
	end

	assign vld_out  = vld_s[QW];
	assign meta_out = meta_s[QW];
	assign quo_out  = quo_s[QW];

endmodule

FILE: sv/lvd_sqrt.sv
// ----------------------------------------------------------------------------
// lvd_sqrt
// Digit-by-digit square root, one root bit per stage, followed by the
// result register that drives the output channel.
// ----------------------------------------------------------------------------
module lvd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  lvd_pkg::meta_t                meta_in,
	input  logic [lvd_pkg::QW-1:0]        quo,
	output logic                          vld_out,
	output logic [lvd_pkg::DW-1:0]        vol_out,
	output logic                          ok_out,
	output lvd_pkg::fault_t               fault_out
);

	localparam int DW = lvd_pkg::DW;
	localparam int SQW = lvd_pkg::SQW;

	logic           vld_s  [0:DW];
	lvd_pkg::meta_t meta_s [0:DW];
	logic [SQW-1:0] rem_s  [0:DW];
	logic [DW-1:0]  root_s [0:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= meta_in;
			rem_s[0]  <= SQW'(quo);
			root_s[0] <= '0;
		end
	end

	// rem tracks x - root^2; adding bit b costs root*2^(b+1) + 2^(2b)
	for (genvar j = 1; j <= DW; j++) begin : g_step
		logic [SQW-1:0] trial;

		assign trial = (SQW'(root_s[j-1]) << (DW - j + 1)) + (SQW'(1) << (2 * (DW - j)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[j] <= meta_s[j-1];
				if (rem_s[j-1] >= trial) begin
					rem_s[j]  <= rem_s[j-1] - trial;
					root_s[j] <= root_s[j-1] | (DW'(1) << (DW - j));
				end else begin
					rem_s[j]  <= rem_s[j-1];
					root_s[j] <= root_s[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fault_out <= meta_s[DW].fault;
			ok_out    <= (meta_s[DW].fault == lvd_pkg::FLT_OK);
			if (meta_s[DW].fault != lvd_pkg::FLT_OK) begin
				vol_out <= '0;
			end else if (meta_s[DW].sat) begin
				vol_out <= '1;
			end else begin
				vol_out <= root_s[DW];
			end
		end
	end

endmodule

FILE: sv/local_volatility_from_derivatives.sv
// ----------------------------------------------------------------------------
// local_volatility_from_derivatives
// Dupire local volatility sqrt(num/den) in Q16.16 from a call price and its
// derivatives.
// ----------------------------------------------------------------------------
// One item enters per clock while in_stall is low, and its result is
// presented at the output having passed 102 register stages: three
// multiply/sum stages, one divider setup stage, 64 one-bit divider stages,
// one root setup stage, 32 one-bit root stages and the output register. The
// whole pipeline advances together and holds only while a result sits at the
// output and out_stall is high; in_stall follows that. The user must write
// rate and dividend yield via the always-ready cfg port (index 0 rate, 1 yield,
// others ignored) while no transaction is in flight; not enforced by the block.
module local_volatility_from_derivatives (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lvd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [lvd_pkg::DW-1:0]                 cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [lvd_pkg::DW-1:0]          strike_price,
	input  logic signed [lvd_pkg::DW-1:0]          maturity,
	input  logic signed [lvd_pkg::DW-1:0]          option_price,
	input  logic signed [lvd_pkg::DW-1:0]          time_slope,
	input  logic signed [lvd_pkg::DW-1:0]          strike_slope,
	input  logic signed [lvd_pkg::DW-1:0]          strike_curvature,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [lvd_pkg::DW-1:0]                 local_vol,
	output logic                                   vol_valid,
	output logic [1:0]                             fault_code
);

	logic signed [lvd_pkg::DW-1:0]    rate_q;
	logic signed [lvd_pkg::DW-1:0]    yield_q;
	logic                             en;
	logic                             vld_s3;
	lvd_pkg::fault_t                  fault_s3;
	logic signed [lvd_pkg::NUM_W-1:0] num_s3;
	logic        [lvd_pkg::DEN_W-1:0] den_s3;
	logic                             dv_vld;
	lvd_pkg::meta_t                   dv_meta;
	logic        [lvd_pkg::QW-1:0]    dv_quo;
	lvd_pkg::fault_t                  fault_o;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= '0;
			yield_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lvd_pkg::REG_RATE:  rate_q  <= cfg_data;
				lvd_pkg::REG_YIELD: yield_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.rate     (rate_q),
		.yield    (yield_q),
		.k        (strike_price),
		.t        (maturity),
		.c        (option_price),
		.ct       (time_slope),
		.ck       (strike_slope),
		.ckk      (strike_curvature),
		.vld_s3   (vld_s3),
		.fault_s3 (fault_s3),
		.num_s3   (num_s3),
		.den_s3   (den_s3)
	);

	lvd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s3),
		.fault_in (fault_s3),
		.num      (num_s3),
		.den      (den_s3),
		.vld_out  (dv_vld),
		.meta_out (dv_meta),
		.quo_out  (dv_quo)
	);

	lvd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (dv_vld),
		.meta_in   (dv_meta),
		.quo       (dv_quo),
		.vld_out   (out_valid),
		.vol_out   (local_vol),
		.ok_out    (vol_valid),
		.fault_out (fault_o)
	);

	assign fault_code = fault_o;

endmodule

FILE: sv/lvd_checker.sv
// ----------------------------------------------------------------------------
// lvd_checker
// Port-level checks of the local volatility block, bound to the top level.
// ----------------------------------------------------------------------------
module lvd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [lvd_pkg::DW-1:0]        local_vol,
	input logic                          vol_valid,
	input logic [1:0]                    fault_code
);

	// a faulted transaction carries no volatility
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault_code != lvd_pkg::FLT_OK) |-> (!vol_valid && local_vol == '0))
		else $error("faulted result with nonzero volatility");

	a_valid_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (vol_valid == (fault_code == lvd_pkg::FLT_OK)))
		else $error("vol_valid disagrees with fault_code");

	// input side holds only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(local_vol)
			&& $stable(fault_code)))
		else $error("stalled result changed");

endmodule

bind local_volatility_from_derivatives lvd_checker u_lvd_checker (.*);

FILE: bench/local_volatility_from_derivatives_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_volatility_from_derivatives_test
// Self-checking bench for the local volatility pipeline. Directed corner
// items and random surface points flow through a bursty driver and a stalling
// receiver. Every accepted transaction is predicted with exact wide
// arithmetic, and every result is compared in order.
// ----------------------------------------------------------------------------
module local_volatility_from_derivatives_test;

	localparam logic [lvd_pkg::CFG_IDX_W-1:0] REG_SPARE = lvd_pkg::CFG_IDX_W'(2);
	localparam int DRAIN_CYCLES = 120;
	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;

	typedef struct {
		logic signed [31:0] k, t, c, ct, ck, ckk;
	} point_t;

	typedef struct {
		logic [31:0]     vol;
		logic            ok;
		lvd_pkg::fault_t fault;
	} vol_res_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [lvd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0, in_stall;
	logic signed [31:0] strike_price = '0, maturity = '0, option_price = '0;
	logic signed [31:0] time_slope = '0, strike_slope = '0, strike_curvature = '0;
	logic out_valid, out_stall = 1'b0;
	logic [31:0] local_vol;
	logic vol_valid;
	logic [1:0] fault_code;

	point_t   point_q[$];
	vol_res_t vol_exp_q[$];
	point_t   cur_point;
	logic signed [31:0] rate_m = '0, yield_m = '0;
	int errors = 0;
	int accepted = 0;

	local_volatility_from_derivatives u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic vol_res_t dupire_vol(point_t p, logic signed [31:0] r,
			logic signed [31:0] q);
		logic signed [191:0] k, num, den;
		logic [191:0] quo;
		logic [127:0] root, cand;
		vol_res_t res;
		res.vol = '0;
		res.ok = 1'b0;
		res.fault = lvd_pkg::FLT_OK;
		if (p.k <= 0 || p.t <= 0) begin
			res.fault = lvd_pkg::FLT_ARG;
		end else if (p.ckk <= 0) begin
			res.fault = lvd_pkg::FLT_DEN;
		end else begin
			k = 192'(p.k);
			num = (192'(p.ct) <<< 32) + (192'(r) - 192'(q)) * k * 192'(p.ck)
				+ ((192'(q) * 192'(p.c)) <<< 16);
			if (num < 0) begin
				res.fault = lvd_pkg::FLT_NUM;
			end else begin
				den = k * k * 192'(p.ckk);
				quo = (192'(num) << 33) / 192'(den);
				if (quo >= (192'(1) << 64)) begin
					res.vol = '1;
				end else begin
					root = '0;
					for (int b = 31; b >= 0; b--) begin
						cand = root | (128'(1) << b);
						if (cand * cand <= 128'(quo))
							root = cand;
					end
					res.vol = root[31:0];
				end
				res.ok = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic signed [31:0] rnd_signed();
		return $signed($urandom) >>> $urandom_range(0, 24);
	endfunction

	function automatic logic signed [31:0] rnd_pos();
		return $signed(($urandom >> $urandom_range(1, 28)) | 32'd1);
	endfunction

	function automatic point_t rnd_point();
		point_t p;
		if ($urandom_range(0, 9) == 0) begin
			p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			p.k = rnd_pos();
			p.t = rnd_pos();
			p.c = rnd_signed();
			p.ct = ($urandom_range(0, 3) == 0) ? rnd_signed() : rnd_pos();
			p.ck = rnd_signed();
			p.ckk = rnd_pos();
		end
		return p;
	endfunction

	// driver: bursts of random length with random gaps
	always @(posedge clk) begin
		static int burst_left = 0, gap_left = 0;
		logic nv;
		nv = in_valid;
		if (in_valid && !in_stall) begin
			vol_exp_q.push_back(dupire_vol(cur_point, rate_m, yield_m));
			accepted++;
			nv = 1'b0;
		end
		if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (point_q.size() > 0) begin
				cur_point = point_q.pop_front();
				strike_price <= cur_point.k;
				maturity <= cur_point.t;
				option_price <= cur_point.c;
				time_slope <= cur_point.ct;
				strike_slope <= cur_point.ck;
				strike_curvature <= cur_point.ckk;
				nv = 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		in_valid <= nv;
	end

	// receiver: random stall pattern plus one long hold-off to back up the pipe
	always @(posedge clk) begin
		static int hold_cnt = 0;
		static bit hold_done = 1'b0;
		static int mode_left = 0, mode = 0;
		if (!hold_done && accepted >= 40) begin
			hold_done = 1'b1;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 60);
			end
			mode_left--;
			out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
		end
	end

	// monitor
	always @(posedge clk) begin
		vol_res_t e;
		if (out_valid && !out_stall) begin
			if (vol_exp_q.size() == 0) begin
				$display("%0t: unexpected result vol=%h valid=%b fault=%0d",
					$time, local_vol, vol_valid, fault_code);
				errors++;
			end else begin
				e = vol_exp_q.pop_front();
				if (local_vol !== e.vol) begin
					$display("%0t: local_vol expected %h actual %h", $time, e.vol, local_vol);
					errors++;
				end
				if (vol_valid !== e.ok) begin
					$display("%0t: vol_valid expected %b actual %b", $time, e.ok, vol_valid);
					errors++;
				end
				if (fault_code !== e.fault) begin
					$display("%0t: fault_code expected %0d actual %0d",
						$time, e.fault, fault_code);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [lvd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == lvd_pkg::REG_RATE)
			rate_m = val;
		else if (idx == lvd_pkg::REG_YIELD)
			yield_m = val;
		cfg_valid <= 1'b0;
	endtask

	// sample at the falling edge so the driver's updates have settled
	task automatic drain();
		do @(negedge clk);
		while (point_q.size() != 0 || in_valid || vol_exp_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic signed [31:0] rates[6], yields[6];
		point_t p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		rates = '{0, SMAX, SMIN, 32'sh0000_0ccd, -32'sh0000_0800, 0};
		yields = '{0, SMIN, SMAX, 32'sh0000_0400, 32'sh0000_1000, 0};
		rates[5] = $urandom;
		yields[5] = rnd_signed();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_reg(lvd_pkg::REG_RATE, rates[ph]);
				write_reg(lvd_pkg::REG_YIELD, yields[ph]);
				write_reg(REG_SPARE, $urandom);
			end
			if (ph == 0 || ph == 1) begin
				// bad strike, bad maturity, curvature not positive, zero and
				// negative numerator, saturating root, extremes of every field
				point_q.push_back('{0, 32'sh10000, 1, 1, 1, 1});
				point_q.push_back('{SMIN, 32'sh10000, 1, 1, 1, 1});
				point_q.push_back('{32'sh10000, 0, 1, 1, 1, 1});
				point_q.push_back('{32'sh10000, SMIN, 1, 1, 1, 1});
				point_q.push_back('{32'sh10000, 32'sh10000, 1, 1, 1, 0});
				point_q.push_back('{32'sh10000, 32'sh10000, 1, 1, 1, SMIN});
				point_q.push_back('{32'sh10000, 32'sh10000, 0, 0, 0, 32'sh10000});
				point_q.push_back('{32'sh10000, 32'sh10000, 0, SMIN, 0, 32'sh10000});
				point_q.push_back('{32'sh10000, 32'sh10000, 0, -1, 0, 32'sh10000});
				point_q.push_back('{1, SMAX, SMAX, SMAX, SMAX, 1});
				point_q.push_back('{SMAX, SMAX, SMIN, SMAX, SMIN, SMAX});
				point_q.push_back('{SMAX, 1, SMAX, 1, SMAX, SMAX});
				point_q.push_back('{32'sh640000, 32'sh8000, 32'sh50000, 32'sh3000,
					-32'sh4000, 32'sh0100});
				point_q.push_back('{32'sh10000, 32'sh10000, 0, 32'sh10000, 0, 32'sh20000});
			end
			for (int i = 0; i < 70; i++) begin
				p = rnd_point();
				point_q.push_back(p);
			end
			drain();
		end
		if (errors == 0 && vol_exp_q.size() == 0)
			$display("** local_volatility_from_derivatives: PASSED **");
		else
			$display("** local_volatility_from_derivatives: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** local_volatility_from_derivatives: FAILED **");
		$finish;
	end

endmodule
